// ===== hw/rtl/running_median_two_heaps_macros.svh =====
// assertion macros for the running median block
// used by running_median_two_heaps.sv, no other dependencies
`ifndef RUNNING_MEDIAN_TWO_HEAPS_MACROS_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_MACROS_SVH

// condition that must hold at every edge out of reset
`define RMH_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define RMH_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/rmh_pkg.sv =====
// shared constants and types for the running median block
// no dependencies
`default_nettype none

package rmh_pkg;

  localparam int unsigned CAPACITY_DEF    = 1024;
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned MEDIAN_W        = 17;
  localparam int unsigned COUNT_W         = 11;

  // operation applied to one sorted row of cells
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_PUSH,
    OP_POPPUSH
  } chain_op_e;

endpackage

`default_nettype wire

// ===== hw/rtl/rmh_stream_if.sv =====
// valid/ready stream interfaces for sample input and median result
// depends on rmh_pkg
`default_nettype none

interface rmh_sample_if #(
  parameter int unsigned W = rmh_pkg::SAMPLE_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface rmh_result_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [rmh_pkg::MEDIAN_W-1:0]   median_x2;
  logic        [rmh_pkg::COUNT_W-1:0]    sample_count;
  logic                                  full_res;

  modport source (output valid, output median_x2, output sample_count, output full_res,
                  input ready);
  modport sink   (input valid, input median_x2, input sample_count, input full_res,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rmh_cell.sv =====
// one slot of a sorted row: holds a value, or inserts or shifts per cycle when its row operation says so
// depends on rmh_pkg
`default_nettype none

module rmh_cell #(
  parameter int unsigned W         = rmh_pkg::SAMPLE_BITS_DEF,
  parameter bit          MAX_ORDER = 1'b1
) (
  input  logic                clk_i,
  input  rmh_pkg::chain_op_e  op_i,
  input  logic signed [W-1:0] x_i,
  input  logic                occ_i,
  input  logic                lead_i,
  input  logic signed [W-1:0] left_val_i,
  input  logic                left_go_i,
  input  logic signed [W-1:0] right_val_i,
  input  logic                right_go_i,
  output logic signed [W-1:0] val_o,
  output logic                go_o
);
  import rmh_pkg::*;

  logic signed [W-1:0] val_q, val_d;
  logic                ahead;

  // new value sorts before this one
  assign ahead = MAX_ORDER ? (x_i > val_q) : (x_i < val_q);
  // insert point is here or earlier
  assign go_o  = !occ_i || ahead;

  always_comb begin
    unique case (op_i)
      OP_HOLD:    val_d = val_q;
      OP_PUSH:    val_d = go_o ? (left_go_i ? left_val_i : x_i) : val_q;
      // head drops out, row shifts toward the head while x is inserted
      OP_POPPUSH: val_d = right_go_i ? ((go_o && !lead_i) ? val_q : x_i) : right_val_i;
      default:    val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

`default_nettype wire

// ===== hw/rtl/rmh_chain.sv =====
// sorted row of cells standing in for one heap, head is the heap top
// depends on rmh_pkg and rmh_cell
`default_nettype none

module rmh_chain #(
  parameter int unsigned W         = rmh_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned DEPTH     = (rmh_pkg::CAPACITY_DEF + 1) / 2,
  parameter bit          MAX_ORDER = 1'b1,
  localparam int unsigned SIZE_W   = $clog2(DEPTH + 1)
) (
  input  logic                clk_i,
  input  rmh_pkg::chain_op_e  op_i,
  input  logic signed [W-1:0] x_i,
  input  logic [SIZE_W-1:0]   size_i,
  output logic signed [W-1:0] head_o
);
  import rmh_pkg::*;

  logic signed [W-1:0] val_w [DEPTH];
  logic                go_w  [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_slot
    logic signed [W-1:0] lval, rval;
    logic                lgo, rgo, occ;

    assign occ = (size_i > SIZE_W'(i));

    if (i == 0) begin : g_first
      assign lval = x_i;
      assign lgo  = 1'b0;
    end else begin : g_mid_l
      assign lval = val_w[i-1];
      assign lgo  = go_w[i-1];
    end

    // past the end counts as empty
    if (i == DEPTH - 1) begin : g_last
      assign rval = x_i;
      assign rgo  = 1'b1;
    end else begin : g_mid_r
      assign rval = val_w[i+1];
      assign rgo  = go_w[i+1];
    end

    rmh_cell #(
      .W         (W),
      .MAX_ORDER (MAX_ORDER)
    ) u_slot (
      .clk_i       (clk_i),
      .op_i        (op_i),
      .x_i         (x_i),
      .occ_i       (occ),
      .lead_i      (i == 0),
      .left_val_i  (lval),
      .left_go_i   (lgo),
      .right_val_i (rval),
      .right_go_i  (rgo),
      .val_o       (val_w[i]),
      .go_o        (go_w[i])
    );
  end

  assign head_o = val_w[0];

endmodule

`default_nettype wire

// ===== hw/rtl/running_median_two_heaps.sv =====
// running median over a sample stream, lower and upper halves in two sorted cell rows
// depends on rmh_pkg, rmh_stream_if, rmh_chain, running_median_two_heaps_macros.svh
//
//  channel    dir  modport  payload                               transfer when
//  sample_i   in   sink     sample                                valid && ready
//  result_o   out  source   median_x2, sample_count, full_res     valid && ready
//
// each item goes through accept, decide (compare against the median), one shift
// of both cell rows, median update into the output register (held while the result stalls)
// the cell rows move by one step per item
// reset clears the sizes, the median and the output valid; cell contents are not cleared
// a stalled result holds the median step, so at most one result waits at the output
// a new sample is taken while the previous result is still waiting
`default_nettype none
`include "running_median_two_heaps_macros.svh"

module running_median_two_heaps #(
  parameter int unsigned CAPACITY    = rmh_pkg::CAPACITY_DEF,
  parameter int unsigned SAMPLE_BITS = rmh_pkg::SAMPLE_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  rmh_sample_if.sink    sample_i,
  rmh_result_if.source  result_o
);
  import rmh_pkg::*;

  localparam int unsigned W          = SAMPLE_BITS;
  localparam int unsigned HEAP_DEPTH = (CAPACITY + 1) / 2;
  localparam int unsigned SIZE_W     = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned TOT_W      = SIZE_W + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEC,
    S_UPD,
    S_MED
  } state_e;

  state_e state_q;

  // control state
  logic [SIZE_W-1:0]   lsize_q, usize_q;
  logic signed [W:0]   median_q;
  logic                full_q;
  logic                out_valid_q;
  chain_op_e           op_lo_q, op_up_q;

  // payload registers
  logic signed [W-1:0] x_q;
  logic signed [W-1:0] val_lo_q, val_up_q;
  logic signed [MEDIAN_W-1:0] out_median_q;
  logic [COUNT_W-1:0]  out_count_q;
  logic                out_full_q;

  // combinational
  logic signed [W-1:0] head_lo, head_up;
  logic [TOT_W-1:0]    total;
  logic                full_d, above;
  logic signed [W+1:0] x2, med_ext;
  chain_op_e           op_lo_d, op_up_d, lo_op, up_op;
  logic signed [W-1:0] val_lo_d, val_up_d;
  logic signed [W:0]   median_d;
  logic                out_free;

  // assertion terms
  logic                sizes_balanced, both_held, drop_out, at_cap;

  assign total  = {1'b0, lsize_q} + {1'b0, usize_q};
  assign full_d = (total >= TOT_W'(CAPACITY));

  // twice the sample against twice the median, both exact
  assign x2      = {x_q[W-1], x_q, 1'b0};
  assign med_ext = {median_q[W], median_q};
  assign above   = (x2 > med_ext);

  // pick the row operations; at most one per row, so one shift does the whole item
  always_comb begin
    op_lo_d  = OP_HOLD;
    op_up_d  = OP_HOLD;
    val_lo_d = x_q;
    val_up_d = x_q;
    priority if (full_d) begin
      // dropped sample, nothing moves
    end else if (lsize_q == usize_q) begin
      if (above) begin
        op_up_d = OP_PUSH;
      end else begin
        op_lo_d = OP_PUSH;
      end
    end else if (lsize_q > usize_q) begin
      if (above) begin
        op_up_d = OP_PUSH;
      end else begin
        // lower top crosses to the upper half, sample replaces it below
        op_lo_d  = OP_POPPUSH;
        op_up_d  = OP_PUSH;
        val_up_d = head_lo;
      end
    end else begin
      if (above) begin
        // upper top crosses to the lower half, sample replaces it above
        op_up_d  = OP_POPPUSH;
        op_lo_d  = OP_PUSH;
        val_lo_d = head_up;
      end else begin
        op_lo_d = OP_PUSH;
      end
    end
  end

  assign lo_op = (state_q == S_UPD) ? op_lo_q : OP_HOLD;
  assign up_op = (state_q == S_UPD) ? op_up_q : OP_HOLD;

  // lower half, largest at the head
  rmh_chain #(
    .W         (W),
    .DEPTH     (HEAP_DEPTH),
    .MAX_ORDER (1'b1)
  ) u_lower (
    .clk_i  (clk_i),
    .op_i   (lo_op),
    .x_i    (val_lo_q),
    .size_i (lsize_q),
    .head_o (head_lo)
  );

  // upper half, smallest at the head
  rmh_chain #(
    .W         (W),
    .DEPTH     (HEAP_DEPTH),
    .MAX_ORDER (1'b0)
  ) u_upper (
    .clk_i  (clk_i),
    .op_i   (up_op),
    .x_i    (val_up_q),
    .size_i (usize_q),
    .head_o (head_up)
  );

  // twice the median from the two heads
  always_comb begin
    priority if (lsize_q == '0 && usize_q == '0) begin
      median_d = '0;
    end else if (lsize_q == usize_q) begin
      median_d = {head_lo[W-1], head_lo} + {head_up[W-1], head_up};
    end else if (lsize_q > usize_q) begin
      median_d = {head_lo, 1'b0};
    end else begin
      median_d = {head_up, 1'b0};
    end
  end

  assign out_free = !out_valid_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lsize_q     <= '0;
      usize_q     <= '0;
      median_q    <= '0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
      op_lo_q     <= OP_HOLD;
      op_up_q     <= OP_HOLD;
    end else begin
      // a new result replaces the one leaving in the same cycle
      if (state_q == S_MED && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (sample_i.valid) begin
            state_q <= S_DEC;
          end
        end
        S_DEC: begin
          op_lo_q <= op_lo_d;
          op_up_q <= op_up_d;
          full_q  <= full_d;
          state_q <= S_UPD;
        end
        S_UPD: begin
          lsize_q <= lsize_q + SIZE_W'(op_lo_q == OP_PUSH);
          usize_q <= usize_q + SIZE_W'(op_up_q == OP_PUSH);
          state_q <= S_MED;
        end
        S_MED: begin
          if (out_free) begin
            median_q <= median_d;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && sample_i.valid) begin
      x_q <= sample_i.sample;
    end
    if (state_q == S_DEC) begin
      val_lo_q <= val_lo_d;
      val_up_q <= val_up_d;
    end
    if (state_q == S_MED && out_free) begin
      out_median_q <= MEDIAN_W'(median_d);
      out_count_q  <= COUNT_W'(total);
      out_full_q   <= full_q;
    end
  end

  assign sample_i.ready        = (state_q == S_IDLE);
  assign result_o.valid        = out_valid_q;
  assign result_o.median_x2    = out_median_q;
  assign result_o.sample_count = out_count_q;
  assign result_o.full_res     = out_full_q;

  assign sizes_balanced = (lsize_q == usize_q) ||
                          ({1'b0, lsize_q} == {1'b0, usize_q} + TOT_W'(1)) ||
                          ({1'b0, usize_q} == {1'b0, lsize_q} + TOT_W'(1));
  assign both_held      = (state_q == S_IDLE) && (lsize_q != '0) && (usize_q != '0);
  assign drop_out       = (state_q == S_MED) && full_q;
  assign at_cap         = (total == TOT_W'(CAPACITY));

  // halves never differ by more than one entry
  `RMH_ASSERT_ALWAYS(a_balance, clk_i, rst_ni, sizes_balanced, "halves out of balance")

  // every lower entry stays at or below every upper entry
  `RMH_ASSERT_IMPLIES(a_order, clk_i, rst_ni, both_held, head_lo <= head_up, "halves out of order")

  // a dropped sample only ever reports a full block
  `RMH_ASSERT_IMPLIES(a_full_count, clk_i, rst_ni, drop_out, at_cap, "drop below capacity")

endmodule

`default_nettype wire

// ===== sim/running_median_two_heaps_checker.sv =====
`timescale 1ns / 100ps
// result checker for the running median block: watches both stream channels,
// predicts every result from its own sorted lower and upper halves, compares fields
// depends on rmh_pkg and rmh_stream_if
module running_median_two_heaps_checker (
  input  logic  clk_i,
  input  logic  rst_ni,
  rmh_sample_if sample_i,
  rmh_result_if result_i,
  output int    fail_count_o,
  output int    pending_o
);
  import rmh_pkg::*;

  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic signed [MEDIAN_W-1:0] median_x2;
    logic [COUNT_W-1:0]         sample_count;
    logic                       full_res;
  } median_result_t;

  // both halves kept sorted ascending: lower top is the last entry, upper top the first
  int             lower_half[$];
  int             upper_half[$];
  int             median_twice = 0;
  median_result_t median_fifo[$];
  int             errors = 0;

  function automatic void put_lower(input int v);
    int i;
    i = 0;
    while (i < lower_half.size() && lower_half[i] <= v) i++;
    lower_half.insert(i, v);
  endfunction

  function automatic void put_upper(input int v);
    int i;
    i = 0;
    while (i < upper_half.size() && upper_half[i] <= v) i++;
    upper_half.insert(i, v);
  endfunction

  function automatic median_result_t predict_median(input int x);
    median_result_t r;
    int             moved;
    bit             above;
    r.full_res = 1'b0;
    if (lower_half.size() + upper_half.size() >= CAPACITY_DEF) begin
      r.full_res = 1'b1;
    end else begin
      above = (2 * x > median_twice);
      if (lower_half.size() == upper_half.size()) begin
        if (above) begin
          put_upper(x);
          median_twice = 2 * upper_half[0];
        end else begin
          put_lower(x);
          median_twice = 2 * lower_half[$];
        end
      end else begin
        if (lower_half.size() > upper_half.size()) begin
          if (above) begin
            put_upper(x);
          end else begin
            moved = lower_half.pop_back();
            put_upper(moved);
            put_lower(x);
          end
        end else begin
          if (above) begin
            moved = upper_half.pop_front();
            put_lower(moved);
            put_upper(x);
          end else begin
            put_lower(x);
          end
        end
        median_twice = upper_half[0] + lower_half[$];
      end
    end
    r.median_x2    = median_twice[MEDIAN_W-1:0];
    r.sample_count = COUNT_W'(lower_half.size() + upper_half.size());
    return r;
  endfunction

  always @(posedge clk_i) begin
    median_result_t got_r;
    median_result_t exp_r;
    if (rst_ni) begin
      // result first: a result can never belong to the sample taken at the same edge
      if (result_i.valid && result_i.ready) begin
        got_r = {result_i.median_x2, result_i.sample_count, result_i.full_res};
        if (median_fifo.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("%0t result with nothing pending: median_x2=%0d count=%0d full=%0b",
                     $time, got_r.median_x2, got_r.sample_count, got_r.full_res);
        end else begin
          exp_r = median_fifo.pop_front();
          if (got_r.median_x2 !== exp_r.median_x2 ||
              got_r.sample_count !== exp_r.sample_count ||
              got_r.full_res !== exp_r.full_res) begin
            errors++;
            if (errors <= REPORT_MAX)
              $display("%0t wrong result: expected median_x2=%0d count=%0d full=%0b, %s",
                       $time, exp_r.median_x2, exp_r.sample_count, exp_r.full_res,
                       $sformatf("got median_x2=%0d count=%0d full=%0b",
                                 got_r.median_x2, got_r.sample_count, got_r.full_res));
          end
        end
      end
      if (sample_i.valid && sample_i.ready) begin
        exp_r = predict_median(int'(sample_i.sample));
        median_fifo.insert(median_fifo.size(), exp_r);
      end
    end
    fail_count_o <= errors;
    pending_o    <= median_fifo.size();
  end

endmodule

// ===== sim/running_median_two_heaps_test.sv =====
`timescale 1ns / 100ps
// testbench top for the running median block: clock, reset, sample stimulus,
// result flow control and verdict; depends on rmh_pkg, rmh_stream_if, the block and its checker
module running_median_two_heaps_test;
  import rmh_pkg::*;

  localparam int unsigned SW           = SAMPLE_BITS_DEF;
  localparam int          SMP_MIN      = -(1 << (SW - 1));
  localparam int          SMP_MAX      = (1 << (SW - 1)) - 1;
  localparam int unsigned ITEM_TOTAL   = 1850;
  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  localparam int unsigned LONG_HOLD    = 300;
  // extra wait after the last result, to cover any straggler
  localparam int unsigned DRAIN_CYCLES = 20;

  // shape of one run of random samples
  typedef enum logic [2:0] {
    MIX_FULL,
    MIX_CLUSTER,
    MIX_RAMP_UP,
    MIX_RAMP_DOWN,
    MIX_EXTREME
  } sample_mix_e;

  logic        clk_i;
  logic        rst_ni;
  int          fail_count;
  int          pending;
  int unsigned cycle_cnt = 0;

  // steady: both sides run without idle cycles
  // hold_req: asks the receiver for one long hold-off
  bit          steady   = 1'b0;
  bit          hold_req = 1'b0;

  // random run state
  int unsigned run_left = 0;
  sample_mix_e run_mix  = MIX_FULL;
  int          run_value = 0;
  int          run_step  = 1;

  // directed opening, starting from the empty block:
  // most negative first (not above the empty median, so it lands low), median at its floor,
  // then enough of the most positive to lift the median to its ceiling,
  // zeros, values next to the median, alternating bit patterns and repeats
  int directed_samples[$] = '{
    -32768, -32768, 32767, 32767, 32767, 32767, 32767,
    0, 0, -1, 1, 21845, -21846, 32766, -32767,
    100, 100, -100, 100, 0
  };

  rmh_sample_if #(.W(SW)) sample_ch ();
  rmh_result_if           result_ch ();

  running_median_two_heaps dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_ch),
    .result_o (result_ch)
  );

  running_median_two_heaps_checker median_watch (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sample_i     (sample_ch),
    .result_i     (result_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // watchdog: a hung handshake or a lost result ends here
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("running_median_two_heaps: mismatch");
      $finish;
    end
  end

  // idle stretch length: mostly a few cycles, now and then a long one
  function automatic int unsigned idle_span();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(3, 1);
    if (r < 95) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  // random samples come in runs: full range, tight clusters (many duplicates and
  // samples equal to the median), rising and falling ramps, and range extremes
  function automatic logic signed [SW-1:0] next_sample();
    int v;
    if (run_left == 0) begin
      run_left  = $urandom_range(40, 8);
      run_mix   = sample_mix_e'($urandom_range(4, 0));
      run_value = int'($urandom_range(SMP_MAX - SMP_MIN)) + SMP_MIN;
      run_step  = $urandom_range(300, 1);
    end
    run_left--;
    case (run_mix)
      MIX_FULL: begin
        v = int'($urandom_range(SMP_MAX - SMP_MIN)) + SMP_MIN;
      end
      MIX_CLUSTER: begin
        v = run_value + int'($urandom_range(8)) - 4;
      end
      MIX_RAMP_UP: begin
        run_value = run_value + run_step;
        v = run_value;
      end
      MIX_RAMP_DOWN: begin
        run_value = run_value - run_step;
        v = run_value;
      end
      default: begin
        case ($urandom_range(4))
          0:       v = SMP_MIN;
          1:       v = SMP_MAX;
          2:       v = -1;
          3:       v = 0;
          default: v = 1;
        endcase
      end
    endcase
    if (v < SMP_MIN) v = SMP_MIN;
    if (v > SMP_MAX) v = SMP_MAX;
    if (run_value < SMP_MIN) run_value = SMP_MIN;
    if (run_value > SMP_MAX) run_value = SMP_MAX;
    return SW'(v);
  endfunction

  // offer one sample from a falling edge and hold it until the transfer;
  // returns at the falling edge after the transfer so the next call can keep valid high
  task automatic send_sample(input logic signed [SW-1:0] value);
    int unsigned gap;
    gap = 0;
    if (!steady && $urandom_range(99) < 35) gap = idle_span();
    if (gap != 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    sample_ch.valid  <= 1'b1;
    sample_ch.sample <= value;
    do @(posedge clk_i); while (sample_ch.ready !== 1'b1);
    @(negedge clk_i);
  endtask

  // sample side: reset, directed opening, random runs, then drain and verdict
  initial begin
    sample_ch.valid  = 1'b0;
    sample_ch.sample = '0;
    rst_ni           = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_samples[i]) send_sample(SW'(directed_samples[i]));

    // the block fills at capacity and drops every later sample with the full flag,
    // so the tail of the random part checks the dropped-sample results
    for (int n = directed_samples.size(); n < ITEM_TOTAL; n++) begin
      if (n == 60) hold_req = 1'b1;
      steady = (n >= 200 && n < 320) || (n >= 900 && n < 1000) || (n >= 1500 && n < 1560);
      send_sample(next_sample());
    end
    sample_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("running_median_two_heaps: match");
    end else begin
      $display("running_median_two_heaps: mismatch");
    end
    $finish;
  end

  // result side: random back-pressure, plus one long hold-off while samples keep
  // coming, so the single output slot fills and the block has to stall its input
  initial begin
    int unsigned stall_left;
    stall_left      = 0;
    result_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        result_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
      end
      if (steady) stall_left = 0;
      if (stall_left != 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else if (steady || $urandom_range(99) < 70) begin
        result_ch.ready <= 1'b1;
      end else begin
        stall_left = idle_span() - 1;
        result_ch.ready <= 1'b0;
      end
    end
  end

endmodule

// ===== running_median_two_heaps.f =====
+incdir+hw/rtl
hw/rtl/rmh_pkg.sv
hw/rtl/rmh_stream_if.sv
hw/rtl/rmh_cell.sv
hw/rtl/rmh_chain.sv
hw/rtl/running_median_two_heaps.sv
sim/running_median_two_heaps_checker.sv
sim/running_median_two_heaps_test.sv
